### design/assert_macros.svh
// Assertion macros for the design files, included by rpm_shift_light_strobe.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/rsls_pkg.sv
// Types and constants of the shift-light strobe block.
package rsls_pkg;

	localparam int RPM_W = 14;
	localparam int TIME_W = 32;
	localparam int DIVR_W = 12;   // rpm - 5500 for rpm in 6000..8000
	localparam int QUO_W = 8;     // period is at most 250 ms
	localparam int DIVD_W = 17;   // width of the numerator 125000
	localparam int CNT_W = 5;

	localparam logic [DIVD_W-1:0] PERIOD_NUM = 17'd125000;
	localparam logic [CNT_W-1:0] DIV_STEPS = 5'd17;

	localparam logic [RPM_W-1:0] STROBE_ON_RPM = 14'd6000;
	localparam logic [RPM_W-1:0] STROBE_TOP_RPM = 14'd8000;
	localparam logic [RPM_W-1:0] STROBE_BASE_RPM = 14'd5500;
	localparam logic [QUO_W-1:0] TOP_PERIOD_MS = 8'd50;

	localparam logic [RPM_W-1:0] ALL_RED_ON_RST = 14'd7500;
	localparam logic [RPM_W-1:0] ALL_RED_OFF_RST = 14'd7300;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_ALL_RED_ON = 1'b0;
	localparam logic REG_ALL_RED_OFF = 1'b1;

	typedef struct packed {
		logic [RPM_W-1:0] engine_rpm;
		logic [TIME_W-1:0] now_ms;
	} upd_t;

	typedef struct packed {
		logic all_red;
		logic strobe_active;
		logic flash_on;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_CMT = 3'b100
	} state_t;

endpackage

### design/rsls_div.sv
// Bit-serial restoring divider: 125000 / divisor, one quotient bit per cycle.
module rsls_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rsls_pkg::DIVR_W-1:0] divisor,
	output logic done,
	output logic [rsls_pkg::QUO_W-1:0] quotient
);

	logic [rsls_pkg::CNT_W-1:0] cnt_q;
	logic done_q;
	logic [rsls_pkg::DIVR_W-1:0] divr_q;
	logic [rsls_pkg::DIVR_W-1:0] rem_q;
	logic [rsls_pkg::DIVD_W-1:0] quo_q;   // dividend bits shift out, quotient bits shift in
	logic [rsls_pkg::DIVR_W:0] trial;
	logic [rsls_pkg::DIVR_W-1:0] diff;
	logic fits;

	assign trial = {rem_q, quo_q[rsls_pkg::DIVD_W-1]};
	assign fits = trial >= {1'b0, divr_q};
	assign diff = trial[rsls_pkg::DIVR_W-1:0] - divr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= rsls_pkg::DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - rsls_pkg::CNT_W'(1);
				if (cnt_q == rsls_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divr_q <= divisor;
			rem_q <= '0;
			quo_q <= rsls_pkg::PERIOD_NUM;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so the difference fits
			rem_q <= fits ? diff : trial[rsls_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[rsls_pkg::DIVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q[rsls_pkg::QUO_W-1:0];

endmodule

### design/rpm_shift_light_strobe.sv
// Shift-light strobe controller: all-red hysteresis and strobe flash phase.
// Path: an accepted item passes through ST_DIV (17 divider steps) and then ST_CMT for
// rpm 6000..8000, otherwise straight to ST_CMT. One item in flight at a time.
// No new item is accepted until the current one has committed its result.
// A waiting result does not block the next accept.
// Reset: thresholds 7500/7300, all-red clear, flash on, toggle time zero.
`include "assert_macros.svh"

module rpm_shift_light_strobe (
	input logic clk,
	input logic arst_n,
	input logic upd_valid,
	output logic upd_ready,
	input rsls_pkg::upd_t upd,
	output logic res_valid,
	input logic res_ready,
	output rsls_pkg::res_t res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rsls_pkg::ADDR_W-1:0] paddr,
	input logic [rsls_pkg::DATA_W-1:0] pwdata,
	output logic [rsls_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	rsls_pkg::state_t state_q;
	rsls_pkg::upd_t upd_q;
	rsls_pkg::res_t res_q;
	logic res_valid_q;

	logic [rsls_pkg::RPM_W-1:0] on_rpm_q;
	logic [rsls_pkg::RPM_W-1:0] off_rpm_q;
	logic red_q;
	logic flash_q;
	logic [rsls_pkg::TIME_W-1:0] last_q;

	logic accept;
	logic need_div;
	logic [rsls_pkg::DIVR_W-1:0] rpm_off;
	logic div_done;
	logic [rsls_pkg::QUO_W-1:0] quotient;
	logic commit;
	logic strobe;
	logic red_set;
	logic red_nxt;
	logic [rsls_pkg::QUO_W-1:0] period;
	logic [rsls_pkg::TIME_W-1:0] elapsed;
	logic toggle;
	logic flash_nxt;

	// APB registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_rpm_q <= rsls_pkg::ALL_RED_ON_RST;
			off_rpm_q <= rsls_pkg::ALL_RED_OFF_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				rsls_pkg::REG_ALL_RED_ON: on_rpm_q <= pwdata[rsls_pkg::RPM_W-1:0];
				rsls_pkg::REG_ALL_RED_OFF: off_rpm_q <= pwdata[rsls_pkg::RPM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rsls_pkg::REG_ALL_RED_ON:
				prdata = {{(rsls_pkg::DATA_W-rsls_pkg::RPM_W){1'b0}}, on_rpm_q};
			rsls_pkg::REG_ALL_RED_OFF:
				prdata = {{(rsls_pkg::DATA_W-rsls_pkg::RPM_W){1'b0}}, off_rpm_q};
			default: prdata = '0;
		endcase
	end

	// input side
	assign upd_ready = (state_q == rsls_pkg::ST_IDLE);
	assign accept = upd_valid && upd_ready;
	assign need_div = (upd.engine_rpm >= rsls_pkg::STROBE_ON_RPM) &&
		(upd.engine_rpm <= rsls_pkg::STROBE_TOP_RPM);
	// offset is at most 2500 whenever the divider starts
	assign rpm_off = rsls_pkg::DIVR_W'(upd.engine_rpm - rsls_pkg::STROBE_BASE_RPM);

	rsls_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && need_div),
		.divisor(rpm_off),
		.done(div_done),
		.quotient(quotient)
	);

	// update of the stored state, applied when the result slot is free
	assign commit = (state_q == rsls_pkg::ST_CMT) && (!res_valid_q || res_ready);
	assign strobe = upd_q.engine_rpm >= rsls_pkg::STROBE_ON_RPM;
	assign red_set = red_q || (upd_q.engine_rpm >= on_rpm_q);
	// clear test runs on the already updated flag
	assign red_nxt = red_set && !(upd_q.engine_rpm < off_rpm_q);
	assign period = (upd_q.engine_rpm > rsls_pkg::STROBE_TOP_RPM) ?
		rsls_pkg::TOP_PERIOD_MS : quotient;
	assign elapsed = upd_q.now_ms - last_q;
	assign toggle = strobe &&
		(elapsed >= {{(rsls_pkg::TIME_W-rsls_pkg::QUO_W){1'b0}}, period});
	assign flash_nxt = strobe ? (flash_q ^ toggle) : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsls_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			red_q <= 1'b0;
			flash_q <= 1'b1;
			last_q <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				rsls_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= need_div ? rsls_pkg::ST_DIV : rsls_pkg::ST_CMT;
					end
				end
				rsls_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= rsls_pkg::ST_CMT;
					end
				end
				rsls_pkg::ST_CMT: begin
					if (commit) begin
						state_q <= rsls_pkg::ST_IDLE;
						res_valid_q <= 1'b1;
						red_q <= red_nxt;
						flash_q <= flash_nxt;
						if (toggle) begin
							last_q <= upd_q.now_ms;
						end
					end
				end
				default: state_q <= rsls_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upd_q <= upd;
		end
		if (commit) begin
			res_q.all_red <= red_nxt;
			res_q.strobe_active <= strobe;
			res_q.flash_on <= flash_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != rsls_pkg::ST_IDLE)
	`ASSERT_ALWAYS(a_done_in_div, !div_done || (state_q == rsls_pkg::ST_DIV))
	`ASSERT_ALWAYS(a_idle_strobe_lit, !res_valid || res.strobe_active || res.flash_on)
	`ASSERT_ALWAYS(a_res_from_commit, !$rose(res_valid) || $past(state_q == rsls_pkg::ST_CMT))

endmodule

### tb/tb.sv
// Testbench of the shift-light strobe block: directed and random updates, scoreboard check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RPM_MAX = (1 << rsls_pkg::RPM_W) - 1;
	localparam int SETTLE_CYCLES = 25;  // settle time after the last result, longer than a full divide

	logic clk;
	logic arst_n;
	logic upd_valid;
	logic upd_ready;
	rsls_pkg::upd_t upd;
	logic res_valid;
	logic res_ready;
	rsls_pkg::res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rsls_pkg::ADDR_W-1:0] paddr;
	logic [rsls_pkg::DATA_W-1:0] pwdata;
	logic [rsls_pkg::DATA_W-1:0] prdata;
	logic pready;

	rpm_shift_light_strobe DUT (
		.clk(clk),
		.arst_n(arst_n),
		.upd_valid(upd_valid),
		.upd_ready(upd_ready),
		.upd(upd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// mirror of the block's registers and state
	logic [rsls_pkg::RPM_W-1:0] on_rpm_cfg;
	logic [rsls_pkg::RPM_W-1:0] off_rpm_cfg;
	logic red_flag_q;
	logic flash_q;
	logic [rsls_pkg::TIME_W-1:0] toggle_ms_q;

	rsls_pkg::res_t lights_expected[$];
	int errors;
	int items_sent;
	int results_seen;
	int settings_used;
	int send_idle_pct;
	int recv_idle_pct;
	logic [rsls_pkg::TIME_W-1:0] cur_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [rsls_pkg::TIME_W-1:0] flash_period(
			input logic [rsls_pkg::RPM_W-1:0] rpm);
		if (rpm > rsls_pkg::STROBE_TOP_RPM)
			return rsls_pkg::TIME_W'(rsls_pkg::TOP_PERIOD_MS);
		return rsls_pkg::TIME_W'(32'd125000 / (32'(rpm) - 32'(rsls_pkg::STROBE_BASE_RPM)));
	endfunction

	function automatic rsls_pkg::res_t predict_lights(input rsls_pkg::upd_t u);
		rsls_pkg::res_t r;
		logic strobe;
		if (!red_flag_q && u.engine_rpm >= on_rpm_cfg)
			red_flag_q = 1'b1;
		// clear test runs on the updated flag
		if (red_flag_q && u.engine_rpm < off_rpm_cfg)
			red_flag_q = 1'b0;
		strobe = (u.engine_rpm >= rsls_pkg::STROBE_ON_RPM);
		if (strobe) begin
			if (rsls_pkg::TIME_W'(u.now_ms - toggle_ms_q) >= flash_period(u.engine_rpm)) begin
				flash_q = ~flash_q;
				toggle_ms_q = u.now_ms;
			end
		end else begin
			flash_q = 1'b1;
		end
		r.all_red = red_flag_q;
		r.strobe_active = strobe;
		r.flash_on = flash_q;
		return r;
	endfunction

	// scoreboard: results first, since a result never belongs to the item of the same edge
	always @(posedge clk) begin
		rsls_pkg::res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (lights_expected.size() == 0) begin
					errors++;
					$display("%0t: result with no item pending: %p", $time, res);
				end else begin
					want = lights_expected.pop_front();
					results_seen++;
					if (res.all_red !== want.all_red || res.strobe_active !== want.strobe_active
							|| res.flash_on !== want.flash_on) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, want, res);
					end
				end
			end
			if (upd_valid && upd_ready) begin
				lights_expected.push_back(predict_lights(upd));
				items_sent++;
			end
		end
	end

	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_update(input logic [rsls_pkg::RPM_W-1:0] rpm,
			input logic [rsls_pkg::TIME_W-1:0] now);
		rsls_pkg::upd_t u;
		u.engine_rpm = rpm;
		u.now_ms = now;
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			upd_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		upd_valid <= 1'b1;
		upd <= u;
		@(posedge clk);
		while (!upd_ready)
			@(posedge clk);
	endtask

	task automatic stop_updates();
		@(negedge clk);
		upd_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		stop_updates();
		while (lights_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write a threshold with junk in the upper bits, then read it back
	task automatic set_threshold(input logic reg_sel, input logic [rsls_pkg::RPM_W-1:0] value);
		logic [rsls_pkg::DATA_W-1:0] junk;
		junk = $urandom;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {junk[rsls_pkg::DATA_W-1:rsls_pkg::RPM_W], value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_sel == rsls_pkg::REG_ALL_RED_ON)
			on_rpm_cfg = value;
		else
			off_rpm_cfg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== rsls_pkg::DATA_W'(value)) begin
			errors++;
			$display("%0t: readback of register %0d expected %0h actual %0h",
				$time, reg_sel, rsls_pkg::DATA_W'(value), prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_thresholds(input logic [rsls_pkg::RPM_W-1:0] on_rpm,
			input logic [rsls_pkg::RPM_W-1:0] off_rpm);
		set_threshold(rsls_pkg::REG_ALL_RED_ON, on_rpm);
		set_threshold(rsls_pkg::REG_ALL_RED_OFF, off_rpm);
		settings_used++;
	endtask

	function automatic logic [rsls_pkg::RPM_W-1:0] clamp_rpm(input int v);
		if (v < 0)
			return '0;
		if (v > RPM_MAX)
			return rsls_pkg::RPM_W'(RPM_MAX);
		return rsls_pkg::RPM_W'(v);
	endfunction

	function automatic logic [rsls_pkg::RPM_W-1:0] pick_rpm();
		case ($urandom_range(9))
			0: return rsls_pkg::RPM_W'($urandom_range(0, 5999));
			1, 2, 3: return rsls_pkg::RPM_W'($urandom_range(6000, 8000));
			4: return rsls_pkg::RPM_W'($urandom_range(8001, RPM_MAX));
			5: return clamp_rpm(int'(on_rpm_cfg) + $urandom_range(0, 6) - 3);
			6: return clamp_rpm(int'(off_rpm_cfg) + $urandom_range(0, 6) - 3);
			7: return ($urandom_range(1)) ? rsls_pkg::RPM_W'($urandom_range(5995, 6005))
				: rsls_pkg::RPM_W'($urandom_range(7995, 8005));
			default: return rsls_pkg::RPM_W'($urandom);
		endcase
	endfunction

	function automatic logic [rsls_pkg::TIME_W-1:0] advance_ms();
		case ($urandom_range(19))
			0: cur_ms = $urandom;
			1: cur_ms = cur_ms - $urandom_range(1, 100);   // time going backwards
			2: cur_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
			default: cur_ms = cur_ms + $urandom_range(0, 260);
		endcase
		return cur_ms;
	endfunction

	task automatic test_strobe_edges();
		send_update(0, 0);
		send_update(5999, 100);
		send_update(6000, 200);
		send_update(6000, 250);
		send_update(8000, 299);
		send_update(8000, 300);
		send_update(8001, 350);
		send_update(RPM_MAX, 399);
		send_update(5999, 400);     // forced on, toggle time kept
		send_update(6001, 400);
		wait_idle();
	endtask

	task automatic test_timestamp_wrap();
		send_update(8001, 32'hFFFF_FFF0);
		send_update(8001, 32'h0000_0021);
		send_update(8001, 32'h0000_0022);
		send_update(7000, 32'h0000_0010);
		wait_idle();
	endtask

	task automatic test_hysteresis();
		send_update(7499, 500);
		send_update(7500, 510);
		send_update(7300, 520);
		send_update(7299, 530);
		send_update(7400, 540);
		wait_idle();
	endtask

	task automatic test_threshold_extremes();
		set_thresholds(7000, 7200);   // on below off: set then clear in one item
		send_update(7100, 600);
		send_update(7200, 610);
		wait_idle();
		set_thresholds(0, 0);
		send_update(0, 620);
		wait_idle();
		set_thresholds(rsls_pkg::RPM_W'(RPM_MAX), rsls_pkg::RPM_W'(RPM_MAX));
		send_update(RPM_MAX - 1, 630);
		send_update(RPM_MAX, 640);
		wait_idle();
		set_thresholds(0, rsls_pkg::RPM_W'(RPM_MAX));
		send_update(RPM_MAX, 650);
		send_update(100, 660);
		wait_idle();
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int count,
			input bit inverted);
		logic [rsls_pkg::RPM_W-1:0] on_rpm;
		on_rpm = rsls_pkg::RPM_W'($urandom_range(6500, 8500));
		if (inverted)
			set_thresholds(on_rpm, rsls_pkg::RPM_W'(on_rpm + $urandom_range(0, 300)));
		else
			set_thresholds(on_rpm, rsls_pkg::RPM_W'(on_rpm - $urandom_range(0, 400)));
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_update(pick_rpm(), advance_ms());
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		upd_valid = 1'b0;
		upd = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		on_rpm_cfg = rsls_pkg::ALL_RED_ON_RST;
		off_rpm_cfg = rsls_pkg::ALL_RED_OFF_RST;
		red_flag_q = 1'b0;
		flash_q = 1'b1;
		toggle_ms_q = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		settings_used = 1;
		send_idle_pct = 36;
		recv_idle_pct = 81;
		cur_ms = 32'd1000;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_strobe_edges();
		test_timestamp_wrap();
		test_hysteresis();
		test_threshold_extremes();
		test_random(36, 81, 142, 1'b0);
		test_random(81, 36, 142, 1'b1);
		test_random(0, 0, 142, 1'b0);

		$display("Covered %0d updates, %0d results checked, %0d threshold settings,",
			items_sent, results_seen, settings_used);
		$display("strobe period edges, timestamp wrap and three idle mixes.");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/rsls_pkg.sv
design/rsls_div.sv
design/rpm_shift_light_strobe.sv
tb/tb.sv
